// ----- hw/rtl/srdiv_pkg.sv -----
// ----------------------------------------------------------------------------
// srdiv_pkg
// Shared constants and types for the signed restoring divider.
// ----------------------------------------------------------------------------
package srdiv_pkg;

  // default operand width
  localparam int WIDTH_DEF = 32;

  // control driven to every cell of the divider row
  typedef struct packed {
    logic load;  // capture magnitudes, clear partial remainder
    logic step;  // one shift-subtract step
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/srdiv_if.sv -----
// ----------------------------------------------------------------------------
// srdiv_in_if / srdiv_out_if
// Valid/ready channels carrying operand words and result words.
// ----------------------------------------------------------------------------
interface srdiv_in_if #(
  parameter int WIDTH = srdiv_pkg::WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] dividend;
  logic signed [WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface srdiv_out_if #(
  parameter int WIDTH = srdiv_pkg::WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] quotient;
  logic signed [WIDTH-1:0] remainder;
  logic                    div_by_zero;
  logic                    overflow;

  modport source (output valid, output quotient, output remainder,
                  output div_by_zero, output overflow, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input div_by_zero, input overflow, output ready);
endinterface

// ----- hw/rtl/srdiv_cell.sv -----
// ----------------------------------------------------------------------------
// srdiv_cell
// One bit slice of the divider: a partial remainder bit, a dividend/quotient
// bit and a divisor bit, with a full subtractor on the shifted remainder.
// ----------------------------------------------------------------------------
module srdiv_cell (
  input  logic                  clk,
  input  srdiv_pkg::cell_ctrl_t ctrl,
  input  logic                  load_n,  // dividend magnitude bit
  input  logic                  load_d,  // divisor magnitude bit
  input  logic                  r_in,    // remainder bit from lower neighbor
  input  logic                  n_in,    // dividend/quotient bit from lower neighbor
  input  logic                  bin,     // borrow from lower neighbor
  input  logic                  take,    // subtraction result is kept
  output logic                  r,
  output logic                  n,
  output logic                  bout
);

  logic d;
  logic diff;

  // full subtractor on the shifted remainder bit
  assign diff = r_in ^ d ^ bin;
  assign bout = (~r_in & d) | (~(r_in ^ d) & bin);

  // bit state: load, then shift and conditionally keep the difference
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      r <= 1'b0;
      n <= load_n;
      d <= load_d;
    end else if (ctrl.step) begin
      r <= take ? diff : r_in;
      n <= n_in;
    end
  end

endmodule

// ----- hw/rtl/srdiv_row.sv -----
// ----------------------------------------------------------------------------
// srdiv_row
// Row of WIDTH divider cells. The remainder and dividend shift up through the
// row each step; the borrow ripples up and decides the quotient bit.
// ----------------------------------------------------------------------------
module srdiv_row #(
  parameter int WIDTH = srdiv_pkg::WIDTH_DEF
) (
  input  logic                  clk,
  input  srdiv_pkg::cell_ctrl_t ctrl,
  input  logic [WIDTH-1:0]      mag_a,
  input  logic [WIDTH-1:0]      mag_b,
  output logic [WIDTH-1:0]      quo,
  output logic [WIDTH-1:0]      rem
);

  logic [WIDTH-1:0] r_bit;
  logic [WIDTH-1:0] n_bit;
  logic [WIDTH:0]   borrow;
  logic             take;

  // keep the difference when the shifted-out bit was set or no borrow left
  assign borrow[0] = 1'b0;
  assign take      = r_bit[WIDTH-1] | ~borrow[WIDTH];

  // cell row
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    logic r_in;
    logic n_in;

    if (i == 0) begin : g_low
      assign r_in = n_bit[WIDTH-1];
      assign n_in = take;
    end else begin : g_mid
      assign r_in = r_bit[i-1];
      assign n_in = n_bit[i-1];
    end

    srdiv_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .load_n (mag_a[i]),
      .load_d (mag_b[i]),
      .r_in   (r_in),
      .n_in   (n_in),
      .bin    (borrow[i]),
      .take   (take),
      .r      (r_bit[i]),
      .n      (n_bit[i]),
      .bout   (borrow[i+1])
    );
  end

  assign quo = n_bit;
  assign rem = r_bit;

endmodule

// ----- hw/rtl/signed_restoring_divider.sv -----
// ----------------------------------------------------------------------------
// signed_restoring_divider
// Signed WIDTH-bit division, quotient truncated toward zero.
// ----------------------------------------------------------------------------
// One operand word in, one result word out. The quotient is truncated toward
// zero and the remainder carries the dividend's sign. A zero divisor sets
// div_by_zero and returns quotient 0 with remainder equal to the dividend; the
// most negative value divided by minus one sets overflow and returns the most
// negative quotient. Each accepted word passes through a load step that
// captures the operand magnitudes, WIDTH shift-subtract steps through a row
// of bit cells (one quotient bit per cycle, limited by the borrow ripple
// along the row), and a step that restores signs into the output register,
// which waits while the previous result is unread; the block then goes idle.
// The output register lets a finished result wait while a new word starts.
// ----------------------------------------------------------------------------
module signed_restoring_divider #(
  parameter int WIDTH = srdiv_pkg::WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  srdiv_in_if.sink    operands,
  srdiv_out_if.source results
);

  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_FIX
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  logic [WIDTH-1:0]      a_reg;
  logic [WIDTH-1:0]      b_reg;
  logic                  dz_reg;
  logic                  ov_reg;
  srdiv_pkg::cell_ctrl_t ctrl;
  logic [WIDTH-1:0]      mag_a;
  logic [WIDTH-1:0]      mag_b;
  logic [WIDTH-1:0]      quo;
  logic [WIDTH-1:0]      rem;
  logic                  neg_a;
  logic                  neg_b;
  logic [WIDTH-1:0]      quo_signed;
  logic [WIDTH-1:0]      rem_signed;
  logic                  out_free;

  // operand magnitudes
  assign neg_a = a_reg[WIDTH-1];
  assign neg_b = b_reg[WIDTH-1];
  assign mag_a = neg_a ? (~a_reg) + WIDTH'(1) : a_reg;
  assign mag_b = neg_b ? (~b_reg) + WIDTH'(1) : b_reg;

  // cell control
  assign ctrl.load = (state == S_LOAD);
  assign ctrl.step = (state == S_RUN);

  srdiv_row #(
    .WIDTH (WIDTH)
  ) u_row (
    .clk   (clk),
    .ctrl  (ctrl),
    .mag_a (mag_a),
    .mag_b (mag_b),
    .quo   (quo),
    .rem   (rem)
  );

  // sign restore and special cases
  assign quo_signed = (neg_a ^ neg_b) ? (~quo) + WIDTH'(1) : quo;
  assign rem_signed = neg_a ? (~rem) + WIDTH'(1) : rem;

  assign operands.ready = (state == S_IDLE) && !rst;
  assign out_free       = !results.valid || results.ready;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && (state != S_FIX)) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (operands.valid) begin
            a_reg  <= operands.dividend;
            b_reg  <= operands.divisor;
            dz_reg <= (operands.divisor == '0);
            ov_reg <= (operands.dividend == {1'b1, {(WIDTH-1){1'b0}}})
                      && (operands.divisor == {WIDTH{1'b1}});
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt   <= CNT_W'(WIDTH - 1);
          state <= S_RUN;
        end
        S_RUN: begin
          if (cnt == '0) begin
            state <= S_FIX;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_FIX: begin
          if (out_free) begin
            results.valid       <= 1'b1;
            results.quotient    <= dz_reg ? '0 : quo_signed;
            results.remainder   <= dz_reg ? a_reg : rem_signed;
            results.div_by_zero <= dz_reg;
            results.overflow    <= ov_reg;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed restoring divider.
// ----------------------------------------------------------------------------
// Operand words go in over the operand channel and result words come back on
// the result channel. A directed table covers sign combinations, divide by
// zero, the most negative value divided by minus one and the range extremes.
// Random words follow in four phases of sender idling and receiver stalls.
// Every result word is checked against its typed result or a signed divide predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int W         = srdiv_pkg::WIDTH_DEF;
  localparam int N_DIRECT  = 24;
  localparam int N_RANDOM  = 1600;
  localparam int MAX_CYC   = 1_000_000;

  localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] S_MAX = ~S_MIN;

  typedef struct packed {
    logic signed [W-1:0] quotient;
    logic signed [W-1:0] remainder;
    logic                div_by_zero;
    logic                overflow;
  } div_result_t;

  // one directed row: operands, and a typed result where it is obvious
  typedef struct packed {
    logic signed [W-1:0] dividend;
    logic signed [W-1:0] divisor;
    logic                typed;
    div_result_t         want;
  } div_vector_t;

  localparam div_vector_t DIRECTED [N_DIRECT] = '{
    '{7,      2,      1'b1, '{3,      1,     1'b0, 1'b0}},
    '{-7,     2,      1'b1, '{-3,     -1,    1'b0, 1'b0}},
    '{7,      -2,     1'b1, '{-3,     1,     1'b0, 1'b0}},
    '{-7,     -2,     1'b1, '{3,      -1,    1'b0, 1'b0}},
    '{5,      0,      1'b1, '{0,      5,     1'b1, 1'b0}},
    '{S_MIN,  0,      1'b1, '{0,      S_MIN, 1'b1, 1'b0}},
    '{S_MAX,  0,      1'b1, '{0,      S_MAX, 1'b1, 1'b0}},
    '{0,      0,      1'b1, '{0,      0,     1'b1, 1'b0}},
    '{-1,     0,      1'b1, '{0,      -1,    1'b1, 1'b0}},
    '{S_MIN,  -1,     1'b1, '{S_MIN,  0,     1'b0, 1'b1}},
    '{S_MIN,  1,      1'b1, '{S_MIN,  0,     1'b0, 1'b0}},
    '{S_MAX,  1,      1'b1, '{S_MAX,  0,     1'b0, 1'b0}},
    '{S_MAX,  -1,     1'b1, '{-S_MAX, 0,     1'b0, 1'b0}},
    '{S_MIN,  S_MIN,  1'b1, '{1,      0,     1'b0, 1'b0}},
    '{S_MAX,  S_MIN,  1'b1, '{0,      S_MAX, 1'b0, 1'b0}},
    '{S_MIN,  S_MAX,  1'b1, '{-1,     -1,    1'b0, 1'b0}},
    '{0,      S_MIN,  1'b1, '{0,      0,     1'b0, 1'b0}},
    '{-1,     S_MIN,  1'b1, '{0,      -1,    1'b0, 1'b0}},
    '{S_MAX,  S_MAX,  1'b1, '{1,      0,     1'b0, 1'b0}},
    '{1,      -1,     1'b1, '{-1,     0,     1'b0, 1'b0}},
    '{S_MIN,  7,      1'b0, '0},
    '{32'h55555555, 3,            1'b0, '0},
    '{32'hAAAAAAAA, 32'h55555555, 1'b0, '0},
    '{12345,  -S_MAX, 1'b0, '0}
  };

  logic clk;
  logic rst;
  int   n_errors = 0;
  int   n_cycles = 0;
  int   idle_pct;
  int   stall_pct;

  div_result_t quotient_due[$];

  srdiv_in_if  #(.WIDTH(W)) op_ch ();
  srdiv_out_if #(.WIDTH(W)) res_ch ();

  signed_restoring_divider #(.WIDTH(W)) dut (
    .clk      (clk),
    .rst      (rst),
    .operands (op_ch.sink),
    .results  (res_ch.source)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // signed divide on unsigned magnitudes, one restoring step per bit
  function automatic div_result_t divide_signed(logic signed [W-1:0] num,
                                                logic signed [W-1:0] den);
    logic [W-1:0] mag_n;
    logic [W-1:0] mag_d;
    logic [W-1:0] quo;
    logic [W-1:0] part;
    logic         carry;
    div_result_t  res;
    res = '0;
    if (den == 0) begin
      res.div_by_zero = 1'b1;
      res.remainder   = num;
      return res;
    end
    mag_n = num[W-1] ? ~num + 1'b1 : num;
    mag_d = den[W-1] ? ~den + 1'b1 : den;
    quo   = '0;
    part  = '0;
    for (int i = W - 1; i >= 0; i--) begin
      carry = part[W-1];
      part  = {part[W-2:0], mag_n[i]};
      if (carry || part >= mag_d) begin
        part   = part - mag_d;
        quo[i] = 1'b1;
      end
    end
    if (num[W-1] ^ den[W-1]) quo = ~quo + 1'b1;
    if (num[W-1]) part = ~part + 1'b1;
    res.quotient  = quo;
    res.remainder = part;
    res.overflow  = (num == S_MIN) && (den == -1);
    return res;
  endfunction

  // random operand, weighted toward sizes that give long quotients
  function automatic logic signed [W-1:0] pick_operand();
    logic signed [W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4: begin
        v = $urandom_range(0, 32);
        v = v - 16;
      end
      5: begin
        case ($urandom_range(0, 4))
          0: v = S_MIN;
          1: v = S_MAX;
          2: v = -1;
          3: v = 1;
          default: v = 0;
        endcase
      end
      6: begin
        v = 1;
        v = v << $urandom_range(0, W - 1);
      end
      default: v = $urandom >> $urandom_range(0, W - 1);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // present one operand word, hold it until accepted
  task automatic drive_operands(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                div_result_t want);
    if ($urandom_range(0, 99) < idle_pct) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    op_ch.valid    <= 1'b1;
    op_ch.dividend <= a;
    op_ch.divisor  <= b;
    do @(posedge clk); while (!op_ch.ready);
    quotient_due.push_back(want);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    div_result_t got;
    div_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.quotient, res_ch.remainder, res_ch.div_by_zero,
              res_ch.overflow};
      if (quotient_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result word q=%0d r=%0d dz=%b ov=%b",
                 $time, got.quotient, got.remainder, got.div_by_zero,
                 got.overflow);
      end else begin
        want = quotient_due.pop_front();
        if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
            got.div_by_zero !== want.div_by_zero || got.overflow !== want.overflow) begin
          n_errors++;
          $display("%0t: mismatch expected q=%0d r=%0d dz=%b ov=%b, got q=%0d r=%0d dz=%b ov=%b",
                   $time, want.quotient, want.remainder, want.div_by_zero,
                   want.overflow, got.quotient, got.remainder, got.div_by_zero,
                   got.overflow);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == MAX_CYC) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    idle_pct       = 0;
    stall_pct      = 0;
    op_ch.valid    <= 1'b0;
    op_ch.dividend <= '0;
    op_ch.divisor  <= '0;
    rst            <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int k = 0; k < N_DIRECT; k++) begin
      drive_operands(DIRECTED[k].dividend, DIRECTED[k].divisor,
                     DIRECTED[k].typed ? DIRECTED[k].want :
                     divide_signed(DIRECTED[k].dividend, DIRECTED[k].divisor));
    end

    // random words over the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        a = pick_operand();
        b = pick_operand();
        if ($urandom_range(0, 29) == 0) b = 0;
        if ($urandom_range(0, 39) == 0) begin
          a = S_MIN;
          b = -1;
        end
        drive_operands(a, b, divide_signed(a, b));
      end
    end
    op_ch.valid <= 1'b0;

    // drain, then let the result channel stay quiet before reporting
    while (quotient_due.size() != 0) @(posedge clk);
    repeat (2 * (W + 3)) @(posedge clk);
    if (n_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
